// ----- rtl/sactl_pkg.sv -----
`default_nettype none

package sactl_pkg;

  // Cache geometry. NUM_SETS and LINE_BYTES are powers of two.
  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 2;
  localparam int LINE_BYTES = 32;

  localparam int ADDR_W   = 32;
  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int SET_W    = (SET_BITS == 0) ? 1 : SET_BITS;
  localparam int LINE_W   = ADDR_W - OFF_BITS;
  localparam int TAG_W    = LINE_W - SET_BITS;
  localparam int WAY_W    = $clog2(NUM_WAYS);
  localparam int AGE_W    = WAY_W;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [NUM_WAYS-1:0][AGE_W-1:0] age_row_t;
  typedef logic [NUM_WAYS-1:0]            valid_row_t;

  // Outcome of one lookup: hit flag, way used and the set's new ages.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    age_row_t         ages;
  } upd_t;

endpackage

`default_nettype wire

// ----- rtl/set_assoc_cache_tag_lru.sv -----
`default_nettype none

// Tag store of a set-associative cache with true LRU replacement. Each word
// on the request channel is a byte address; the block drops the line offset,
// splits the line number into set index and tag, and answers with one word
// that reports hit or miss and the way that hit or was filled. When an
// address is accepted the set's tag row and age row are read into registers
// from two synchronous memories; then the tags are compared, the victim is
// chosen, the ages are updated and both rows are written back. A new address
// is taken the cycle after that write, not before. The answer sits in an
// output register; a lookup that finds that register still full and stalled
// waits with its write-back until the register frees up. Valid bits live in
// flip-flops and clear at reset, so there is no clearing pass; a set whose
// valid bits are all clear reads its ages as the reset order, way w holding
// age w.
module set_assoc_cache_tag_lru (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [sactl_pkg::ADDR_W-1:0]  addr,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic                               hit,
  output logic                               way
);

  logic [sactl_pkg::LINE_W-1:0]  line_num;
  logic [sactl_pkg::SET_W-1:0]   set_idx;
  logic [sactl_pkg::TAG_W-1:0]   tag_in;

  // Lookup in flight, with its set, tag and valid row captured at accept.
  logic                          busy;
  logic [sactl_pkg::SET_W-1:0]   set_q;
  logic [sactl_pkg::TAG_W-1:0]   tag_q;
  sactl_pkg::valid_row_t         valid_q;

  // Row memories and their registered read data.
  sactl_pkg::tag_row_t           tag_mem [sactl_pkg::NUM_SETS];
  sactl_pkg::age_row_t           age_mem [sactl_pkg::NUM_SETS];
  sactl_pkg::tag_row_t           tag_rd;
  sactl_pkg::age_row_t           age_rd;

  sactl_pkg::valid_row_t         valid [sactl_pkg::NUM_SETS];

  sactl_pkg::upd_t               upd;
  sactl_pkg::tag_row_t           tag_row_next;
  sactl_pkg::valid_row_t         valid_row_next;
  logic                          accept;
  logic                          commit;

  assign line_num = addr[sactl_pkg::ADDR_W-1:sactl_pkg::OFF_BITS];
  assign set_idx  = sactl_pkg::SET_W'(line_num % sactl_pkg::LINE_W'(sactl_pkg::NUM_SETS));
  assign tag_in   = sactl_pkg::TAG_W'(line_num >> sactl_pkg::SET_BITS);

  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  // A lookup in flight finishes only when the output register can take its answer.
  assign commit    = busy && (!rsp_valid || !rsp_stall);

  sactl_repl u_repl (
    .tag       (tag_q),
    .tag_row   (tag_rd),
    .age_row   (age_rd),
    .valid_row (valid_q),
    .upd       (upd)
  );

  always_comb begin
    tag_row_next   = tag_rd;
    valid_row_next = valid_q;
    if (!upd.hit) begin
      tag_row_next[upd.way]   = tag_q;
      valid_row_next[upd.way] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_rd <= tag_mem[set_idx];
      age_rd <= age_mem[set_idx];
    end
    if (commit) begin
      tag_mem[set_q] <= tag_row_next;
      age_mem[set_q] <= upd.ages;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q   <= set_idx;
      tag_q   <= tag_in;
      valid_q <= valid[set_idx];
    end
    if (commit) begin
      hit <= upd.hit;
      way <= upd.way[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      for (int s = 0; s < sactl_pkg::NUM_SETS; s++) begin
        valid[s] <= '0;
      end
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        rsp_valid      <= 1'b1;
        valid[set_q]   <= valid_row_next;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted address did not start a lookup");

  a_free_output_commits: assert property (@(posedge clk) disable iff (rst)
    busy && !rsp_valid |=> rsp_valid && !busy)
    else $error("lookup with a free output register did not finish");

  a_used_way_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> valid[$past(set_q)][$past(upd.way)])
    else $error("way used by a lookup is not valid afterward");

  a_used_way_youngest: assert property (@(posedge clk) disable iff (rst)
    commit |-> upd.ages[upd.way] == '0)
    else $error("way used by a lookup is not the most recent");
`endif

endmodule

`default_nettype wire

// ----- rtl/sactl_repl.sv -----
`default_nettype none

// Tag compare, victim choice and age update for one set row.
module sactl_repl (
  input  wire logic [sactl_pkg::TAG_W-1:0] tag,
  input  wire sactl_pkg::tag_row_t         tag_row,
  input  wire sactl_pkg::age_row_t         age_row,
  input  wire sactl_pkg::valid_row_t       valid_row,
  output sactl_pkg::upd_t                  upd
);

  sactl_pkg::age_row_t               ages;
  logic                              hit;
  logic [sactl_pkg::WAY_W-1:0]       hit_way;
  logic [sactl_pkg::WAY_W-1:0]       free_way;
  logic [sactl_pkg::WAY_W-1:0]       old_way;
  logic [sactl_pkg::WAY_W-1:0]       way;
  logic [sactl_pkg::AGE_W-1:0]       cur;

  always_comb begin
    // A set with no valid way was never written, so its ages still
    // hold the reset permutation.
    for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
      if (valid_row == '0) begin
        ages[w] = sactl_pkg::AGE_W'(w);
      end else begin
        ages[w] = age_row[w];
      end
    end

    hit      = 1'b0;
    hit_way  = '0;
    free_way = '0;
    old_way  = '0;
    // Walk downward so that the lowest qualifying way wins.
    for (int w = sactl_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_row[w] && (tag_row[w] == tag)) begin
        hit     = 1'b1;
        hit_way = sactl_pkg::WAY_W'(w);
      end
      if (!valid_row[w]) begin
        free_way = sactl_pkg::WAY_W'(w);
      end
      if (ages[w] == sactl_pkg::AGE_W'(sactl_pkg::NUM_WAYS - 1)) begin
        old_way = sactl_pkg::WAY_W'(w);
      end
    end

    if (hit) begin
      way = hit_way;
    end else if (valid_row != '1) begin
      way = free_way;
    end else begin
      way = old_way;
    end

    cur = ages[way];
    for (int k = 0; k < sactl_pkg::NUM_WAYS; k++) begin
      if (ages[k] < cur) begin
        upd.ages[k] = ages[k] + 1'b1;
      end else begin
        upd.ages[k] = ages[k];
      end
    end
    upd.ages[way] = '0;
    upd.hit       = hit;
    upd.way       = way;
  end

endmodule

`default_nettype wire

// ----- dv/set_assoc_cache_tag_lru_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the tag store of a 2-way set-associative cache with
// true LRU replacement. Every accepted request word is run through a local
// model of the tag, valid and age arrays, and the outcome it predicts is queued.
// Every accepted response word must match the oldest queued outcome.
module set_assoc_cache_tag_lru_tb;

  localparam int RANDOM_WORDS = 1533;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  // What one lookup reports: hit flag and the way that hit or was filled.
  typedef struct packed {
    logic hit;
    logic way;
  } lookup_res_t;

  // One row of the directed sequence. When typed is set, the outcome in the
  // row is the one checked; otherwise the local model supplies it.
  typedef struct packed {
    logic [sactl_pkg::ADDR_W-1:0] a;
    logic                         typed;
    logic                         hit;
    logic                         way;
  } probe_row_t;

  logic                         clk;
  logic                         rst;
  logic                         req_valid;
  logic                         req_stall;
  logic [sactl_pkg::ADDR_W-1:0] addr;
  logic                         rsp_valid;
  logic                         rsp_stall;
  logic                         hit;
  logic                         way;

  set_assoc_cache_tag_lru dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .addr      (addr),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .hit       (hit),
    .way       (way)
  );

  // Local copy of the cache state. Ages of a set always stay a permutation of
  // 0..NUM_WAYS-1, with 0 the most recent way.
  logic [sactl_pkg::TAG_W-1:0] line_tag   [sactl_pkg::NUM_SETS][sactl_pkg::NUM_WAYS];
  logic                        line_valid [sactl_pkg::NUM_SETS][sactl_pkg::NUM_WAYS];
  logic [sactl_pkg::AGE_W-1:0] line_age   [sactl_pkg::NUM_SETS][sactl_pkg::NUM_WAYS];

  lookup_res_t pending_lookups[$];
  int          n_fail = 0;
  int          idle_cycles = 0;

  // When calm is set, neither side inserts gaps, so long back-to-back stretches
  // alternate with stretches full of bubbles and stalls.
  bit calm = 1'b0;

  // The directed sequence. Set 0 and set 63 (the top address) are exercised
  // first: in each a cold miss fills way 0 and the same line at another byte
  // hits. In set 0 a second tag takes the other invalid way; once the set is
  // full a third tag evicts the least recent way. A tag of zero in an empty
  // set must miss, since tags of invalid ways are never compared. Later rows,
  // where the ages are harder to follow by eye, are checked by the model.
  probe_row_t probes [17] = '{
    '{32'h0000_0000, 1'b1, 1'b0, 1'b0},
    '{32'h0000_001F, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
    '{32'hFFFF_FFE0, 1'b1, 1'b1, 1'b0},
    '{32'h0000_0800, 1'b1, 1'b0, 1'b1},
    '{32'h0000_0000, 1'b1, 1'b1, 1'b0},
    '{32'h0000_1000, 1'b1, 1'b0, 1'b1},
    '{32'h0000_0800, 1'b0, 1'b0, 1'b0},
    '{32'h0000_1000, 1'b0, 1'b0, 1'b0},
    '{32'hFFFF_F7E0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_07E0, 1'b0, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0020, 1'b0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Looks up one address in the local cache copy and updates it: a hit
  // refreshes the hitting way, a miss fills the first invalid way or else the
  // oldest one. The chosen way becomes age 0 and every more recent way ages.
  function automatic lookup_res_t lru_lookup(input logic [sactl_pkg::ADDR_W-1:0] a);
    int unsigned                 s;
    int unsigned                 pick;
    logic [sactl_pkg::TAG_W-1:0] t;
    logic [sactl_pkg::AGE_W-1:0] old_age;
    bit                          found;
    lookup_res_t                 r;
    s     = (a >> sactl_pkg::OFF_BITS) % sactl_pkg::NUM_SETS;
    t     = sactl_pkg::TAG_W'(a >> (sactl_pkg::OFF_BITS + sactl_pkg::SET_BITS));
    found = 1'b0;
    pick  = 0;
    for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
      if (!found && line_valid[s][w] && line_tag[s][w] == t) begin
        found = 1'b1;
        pick  = w;
      end
    end
    r.hit = found;
    if (!found) begin
      for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
        if (!found && !line_valid[s][w]) begin
          found = 1'b1;
          pick  = w;
        end
      end
      for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
        if (!found && line_age[s][w] == sactl_pkg::NUM_WAYS - 1) begin
          found = 1'b1;
          pick  = w;
        end
      end
      line_tag[s][pick]   = t;
      line_valid[s][pick] = 1'b1;
    end
    old_age = line_age[s][pick];
    for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
      if (line_age[s][w] < old_age) line_age[s][w] = line_age[s][w] + 1'b1;
    end
    line_age[s][pick] = '0;
    r.way = pick[0];
    return r;
  endfunction

  // Length of the next bubble or stall: mostly none or short, now and then a
  // long one, and none at all while calm is set.
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request word, possibly after a bubble, and waits until it is
  // taken. Valid is only lowered when a bubble goes in, so it never drops and
  // rises in the same step. The expected outcome is queued at acceptance.
  task automatic send_word(input logic [sactl_pkg::ADDR_W-1:0] a, input logic typed,
                           input lookup_res_t typed_res);
    int          gap;
    lookup_res_t res;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    addr      <= a;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    res = lru_lookup(a);
    pending_lookups.insert(pending_lookups.size(), typed ? typed_res : res);
  endtask

  initial begin : calm_toggle
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // Response side: checks every accepted word against the oldest expectation
  // and drives a random stall pattern for the next cycle.
  initial begin : rsp_side
    int          stall_left;
    lookup_res_t want;
    stall_left = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_lookups.size() == 0) begin
          $error("response word with no lookup pending: hit %0b way %0b", hit, way);
          n_fail++;
        end else begin
          want = pending_lookups.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, hit);
            n_fail++;
          end
          if (way !== want.way) begin
            $error("way: expected %0b, got %0b", want.way, way);
            n_fail++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else stall_left = idle_len();
      rsp_stall <= (stall_left > 0);
    end
  end

  // Watchdog: a stretch with no word moving on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("set_assoc_cache_tag_lru_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [sactl_pkg::TAG_W-1:0]    tag_pool [sactl_pkg::NUM_WAYS+1];
    logic [sactl_pkg::SET_BITS-1:0] hot_set  [4];
    logic [sactl_pkg::TAG_W-1:0]    t;
    logic [sactl_pkg::SET_BITS-1:0] s;
    logic [sactl_pkg::OFF_BITS-1:0] off;
    logic [sactl_pkg::ADDR_W-1:0]   a;
    int unsigned                    r;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    addr      <= '0;

    // The model starts the way the block does after reset: nothing valid and
    // way w of every set holding age w.
    for (int i = 0; i < sactl_pkg::NUM_SETS; i++) begin
      for (int w = 0; w < sactl_pkg::NUM_WAYS; w++) begin
        line_tag[i][w]   = '0;
        line_valid[i][w] = 1'b0;
        line_age[i][w]   = sactl_pkg::AGE_W'(w);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) begin
      send_word(probes[i].a, probes[i].typed, {probes[i].hit, probes[i].way});
    end

    // Random part. Most words go to a few hot sets with one more tag in play
    // than there are ways, so hits, fills and LRU evictions all happen often.
    // Some use a random set with the same tags, and the rest are fully random
    // addresses, which also toggle every address bit. Pools change every few
    // hundred words.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 200 == 0) begin
        foreach (tag_pool[k]) tag_pool[k] = sactl_pkg::TAG_W'($urandom);
        foreach (hot_set[k]) begin
          hot_set[k] = sactl_pkg::SET_BITS'($urandom_range(0, sactl_pkg::NUM_SETS - 1));
        end
      end
      r   = $urandom_range(0, 99);
      t   = tag_pool[$urandom_range(0, sactl_pkg::NUM_WAYS)];
      off = sactl_pkg::OFF_BITS'($urandom_range(0, sactl_pkg::LINE_BYTES - 1));
      if (r < 70) begin
        s = hot_set[$urandom_range(0, 3)];
        a = {t, s, off};
      end else if (r < 85) begin
        s = sactl_pkg::SET_BITS'($urandom_range(0, sactl_pkg::NUM_SETS - 1));
        a = {t, s, off};
      end else begin
        a = $urandom;
      end
      send_word(a, 1'b0, '0);
    end

    req_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    // Keep the clock running so that a stray extra response word would be seen.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("set_assoc_cache_tag_lru_tb: clean");
    end else begin
      $display("set_assoc_cache_tag_lru_tb: errors");
    end
    $finish;
  end

endmodule
